// ===== sv/sges_pkg.sv =====
package sges_pkg;

  localparam int unsigned MaxWidth = 4096;
  localparam int unsigned XW       = $clog2(MaxWidth);
  localparam int unsigned DimW     = XW + 1;
  localparam int unsigned QDepth   = 2;

  typedef struct packed {
    logic        start_of_frame;
    logic [31:0] pixel_argb;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic [11:0] out_x;
    logic [11:0] out_y;
    logic        was_smoothed;
    logic        last_of_run;
  } out_word_t;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_STRENGTH = 2'd2,
    REG_THRESH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [8:0]  smoothing_strength;
    logic [8:0]  edge_threshold;
  } cfg_t;

  typedef struct packed {
    logic [8:0][31:0] win;
    logic [31:0]      pix;
    logic [11:0]      x;
    logic [11:0]      y;
    logic             interior;
    logic             border;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LUMA,
    B_GRAD,
    B_SQ,
    B_CMP,
    B_BLEND,
    B_EMIT_C,
    B_EMIT_B
  } back_state_t;

  function automatic logic [12:0] clamp_dim(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > 13'(MaxWidth)) begin
      r = 13'(MaxWidth);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [8:0] sat_q8(input logic [8:0] v);
    return (v > 9'd256) ? 9'd256 : v;
  endfunction

  function automatic logic [15:0] luma(input logic [31:0] p);
    logic [15:0] r;
    r = 16'(16'd77 * p[23:16]) + 16'(16'd150 * p[15:8]) + 16'(16'd29 * p[7:0]);
    return r;
  endfunction

endpackage

// ===== sv/sges_fifo.sv =====
module sges_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sges_pkg::job_t    push_data,
  output logic              full,
  input  logic              pop,
  output sges_pkg::job_t    pop_data,
  output logic              empty
);

  sges_pkg::job_t mem_r [sges_pkg::QDepth];
  logic [$clog2(sges_pkg::QDepth)-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [$clog2(sges_pkg::QDepth):0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == ($clog2(sges_pkg::QDepth)+1)'(sges_pkg::QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop && !empty) begin
      rp_nxt = rp_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/sges_front.sv =====
module sges_front (
  input  logic               clk,
  input  logic               rst_n,
  input  sges_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  sges_pkg::in_word_t in_word,
  output logic               push,
  output sges_pkg::job_t     push_data,
  input  logic               full
);

  logic [31:0] upper_mem [sges_pkg::MaxWidth];
  logic [31:0] middle_mem [sges_pkg::MaxWidth];

  sges_pkg::front_state_t state_r, state_nxt;
  logic [11:0] cc_r, cc_nxt, lc_r, lc_nxt;
  logic [11:0] x_cur, y_cur, x_r, y_r;
  logic [31:0] pix_r, rd_up_r, rd_mid_r;
  logic        int_r, bord_r;
  logic [8:0][31:0] win_r, win_nxt;
  logic [12:0] w, h, x_inc, y_inc;
  logic        accept;

  assign w = sges_pkg::clamp_dim(cfg.frame_width);
  assign h = sges_pkg::clamp_dim(cfg.frame_height);

  always_comb begin
    x_cur = cc_r;
    y_cur = lc_r;
    if (in_word.start_of_frame || ({1'b0, cc_r} >= w)) begin
      x_cur = '0;
    end
    if (in_word.start_of_frame || ({1'b0, lc_r} >= h)) begin
      y_cur = '0;
    end
  end

  assign x_inc = {1'b0, x_cur} + 13'd1;
  assign y_inc = {1'b0, y_cur} + 13'd1;

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sges_pkg::F_IDLE: begin
        if (in_valid) begin
          state_nxt = sges_pkg::F_PUSH;
        end
      end
      sges_pkg::F_PUSH: begin
        if (!full) begin
          state_nxt = sges_pkg::F_IDLE;
        end
      end
      default: state_nxt = sges_pkg::F_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = 1'b1;
    push     = 1'b0;
    unique case (state_r)
      sges_pkg::F_IDLE: in_stall = 1'b0;
      sges_pkg::F_PUSH: push     = !full;
      default:          in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    cc_nxt = cc_r;
    lc_nxt = lc_r;
    if (accept) begin
      if (x_inc >= w) begin
        cc_nxt = '0;
        lc_nxt = (y_inc >= h) ? 12'd0 : y_inc[11:0];
      end else begin
        cc_nxt = x_inc[11:0];
        lc_nxt = y_cur;
      end
    end
  end

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = rd_up_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = rd_mid_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = pix_r;
  end

  assign push_data.win      = win_nxt;
  assign push_data.pix      = pix_r;
  assign push_data.x        = x_r;
  assign push_data.y        = y_r;
  assign push_data.interior = int_r;
  assign push_data.border   = bord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sges_pkg::F_IDLE;
      cc_r    <= '0;
      lc_r    <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cc_r    <= cc_nxt;
      lc_r    <= lc_nxt;
      if (push) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r  <= in_word.pixel_argb;
      x_r    <= x_cur;
      y_r    <= y_cur;
      int_r  <= (x_cur >= 12'd2) && (y_cur >= 12'd2);
      bord_r <= (x_cur == 12'd0) || (y_cur == 12'd0) ||
                ({1'b0, x_cur} == w - 13'd1) || ({1'b0, y_cur} == h - 13'd1);
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_mid_r          <= middle_mem[x_cur];
      middle_mem[x_cur] <= in_word.pixel_argb;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up_r <= upper_mem[x_cur];
    end
    if (push) begin
      upper_mem[x_r] <= rd_mid_r;
    end
  end

endmodule

// ===== sv/sges_back.sv =====
module sges_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sges_pkg::cfg_t      cfg,
  output logic                pop,
  input  sges_pkg::job_t      pop_data,
  input  logic                empty,
  output logic                out_valid,
  input  logic                out_stall,
  output sges_pkg::out_word_t out_word
);

  sges_pkg::back_state_t state_r, state_nxt;
  sges_pkg::job_t        job_r;
  logic [8:0][15:0]      luma_r;
  logic signed [18:0]    gx_r, gy_r, gx_c, gy_c;
  logic signed [37:0]    sqx, sqy;
  logic [35:0]           gx2_r, gy2_r;
  logic [15:0]           tt_r;
  logic [31:0]           tt2_r;
  logic [2:0][19:0]      gq_r, gq_c;
  logic                  edge_r;
  logic [31:0]           res_r, res_c;
  logic [8:0]            s_sat, s_inv;
  logic [36:0]           mag;

  assign s_sat = sges_pkg::sat_q8(cfg.smoothing_strength);
  assign s_inv = 9'd256 - s_sat;

  always_comb begin
    logic signed [18:0] l [9];
    for (int i = 0; i < 9; i++) begin
      l[i] = $signed({3'b000, luma_r[i]});
    end
    gx_c = -l[0] + l[2] - (l[3] <<< 1) + (l[5] <<< 1) - l[6] + l[8];
    gy_c = -l[0] - (l[1] <<< 1) - l[2] + l[6] + (l[7] <<< 1) + l[8];
  end

  always_comb begin
    logic [9:0] cs, es;
    for (int c = 0; c < 3; c++) begin
      cs = 10'(job_r.win[0][8*c +: 8]) + 10'(job_r.win[2][8*c +: 8]) +
           10'(job_r.win[6][8*c +: 8]) + 10'(job_r.win[8][8*c +: 8]);
      es = 10'(job_r.win[1][8*c +: 8]) + 10'(job_r.win[3][8*c +: 8]) +
           10'(job_r.win[5][8*c +: 8]) + 10'(job_r.win[7][8*c +: 8]);
      gq_c[c] = 20'(20'd317 * cs) + 20'(20'd506 * es) +
                20'(20'd803 * job_r.win[4][8*c +: 8]);
    end
  end

  assign sqx = gx_r * gx_r;
  assign sqy = gy_r * gy_r;
  assign mag = {1'b0, gx2_r} + {1'b0, gy2_r};

  always_comb begin
    logic [15:0] a;
    logic [28:0] b;
    logic [29:0] sum;
    res_c = job_r.win[4];
    for (int c = 0; c < 3; c++) begin
      a   = 16'(job_r.win[4][8*c +: 8] * s_inv);
      b   = 29'(gq_r[c] * s_sat);
      sum = {2'b00, a, 12'd0} + {1'b0, b};
      if (edge_r) begin
        res_c[8*c +: 8] = sum[27:20];
      end
    end
  end

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sges_pkg::B_IDLE: begin
        if (!empty) begin
          if (pop_data.interior) begin
            state_nxt = sges_pkg::B_LUMA;
          end else if (pop_data.border) begin
            state_nxt = sges_pkg::B_EMIT_B;
          end
        end
      end
      sges_pkg::B_LUMA:  state_nxt = sges_pkg::B_GRAD;
      sges_pkg::B_GRAD:  state_nxt = sges_pkg::B_SQ;
      sges_pkg::B_SQ:    state_nxt = sges_pkg::B_CMP;
      sges_pkg::B_CMP:   state_nxt = sges_pkg::B_BLEND;
      sges_pkg::B_BLEND: state_nxt = sges_pkg::B_EMIT_C;
      sges_pkg::B_EMIT_C: begin
        if (!out_stall) begin
          state_nxt = job_r.border ? sges_pkg::B_EMIT_B : sges_pkg::B_IDLE;
        end
      end
      sges_pkg::B_EMIT_B: begin
        if (!out_stall) begin
          state_nxt = sges_pkg::B_IDLE;
        end
      end
      default: state_nxt = sges_pkg::B_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    out_word  = '0;
    unique case (state_r)
      sges_pkg::B_IDLE: pop = !empty;
      sges_pkg::B_EMIT_C: begin
        out_valid             = 1'b1;
        out_word.out_pixel    = res_r;
        out_word.out_x        = job_r.x - 12'd1;
        out_word.out_y        = job_r.y - 12'd1;
        out_word.was_smoothed = edge_r;
        out_word.last_of_run  = !job_r.border;
      end
      sges_pkg::B_EMIT_B: begin
        out_valid             = 1'b1;
        out_word.out_pixel    = job_r.pix;
        out_word.out_x        = job_r.x;
        out_word.out_y        = job_r.y;
        out_word.was_smoothed = 1'b0;
        out_word.last_of_run  = 1'b1;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sges_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_data;
    end
    if (state_r == sges_pkg::B_LUMA) begin
      for (int i = 0; i < 9; i++) begin
        luma_r[i] <= sges_pkg::luma(job_r.win[i]);
      end
    end
    if (state_r == sges_pkg::B_GRAD) begin
      gx_r <= gx_c;
      gy_r <= gy_c;
      gq_r <= gq_c;
      tt_r <= 16'(sges_pkg::sat_q8(cfg.edge_threshold) * 8'd255);
    end
    if (state_r == sges_pkg::B_SQ) begin
      gx2_r <= sqx[35:0];
      gy2_r <= sqy[35:0];
      tt2_r <= tt_r * tt_r;
    end
    if (state_r == sges_pkg::B_CMP) begin
      edge_r <= mag > {5'd0, tt2_r};
    end
    if (state_r == sges_pkg::B_BLEND) begin
      res_r <= res_c;
    end
  end

endmodule

// ===== sv/sobel_gated_edge_smoothing.sv =====
// the front reads the line stores when it takes an input word, then updates the window and pushes the job;
// it takes no new input word until that push is done, and a full queue holds it in the push state
// the back pops a job and emits a border word directly, or runs an interior pixel through the serial luma,
// gradient, square, compare, blend and emit steps (plus a border emit if needed); a 2-deep queue parts them
// reset: synchronous active-low rst_n clears coordinates, window, queue and state machines
// and loads the registers with 640, 480, 128 and 26; line stores are not cleared
module sobel_gated_edge_smoothing (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  sges_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sges_pkg::out_word_t out_word
);

  sges_pkg::cfg_t cfg_r;
  sges_pkg::job_t push_data, pop_data;
  logic           push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width        <= 13'd640;
      cfg_r.frame_height       <= 13'd480;
      cfg_r.smoothing_strength <= 9'd128;
      cfg_r.edge_threshold     <= 9'd26;
    end else if (cfg_we) begin
      unique case (sges_pkg::cfg_reg_t'(cfg_index))
        sges_pkg::REG_WIDTH:    cfg_r.frame_width        <= cfg_data;
        sges_pkg::REG_HEIGHT:   cfg_r.frame_height       <= cfg_data;
        sges_pkg::REG_STRENGTH: cfg_r.smoothing_strength <= cfg_data[8:0];
        sges_pkg::REG_THRESH:   cfg_r.edge_threshold     <= cfg_data[8:0];
        default:                cfg_r                    <= cfg_r;
      endcase
    end
  end

  sges_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  sges_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  sges_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== sv/sges_checker.sv =====
module sges_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sges_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front took a word while still updating the window");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last_of_run |=> out_valid && out_word.last_of_run)
    else $error("border word did not follow the interior word");

  a_smooth_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.was_smoothed |-> out_word.out_x != 12'd0 && out_word.out_y != 12'd0)
    else $error("smoothed word on the frame border");

endmodule

bind sobel_gated_edge_smoothing sges_checker u_sges_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/sv/sobel_gated_edge_smoothing_tb.sv =====
`timescale 1ns / 100ps

module sobel_gated_edge_smoothing_tb;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;
  logic      in_valid;
  logic      in_stall;
  sges_pkg::in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  sges_pkg::out_word_t out_word;

  sobel_gated_edge_smoothing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // predictor state
  logic [12:0] frame_w;
  logic [12:0] frame_h;
  logic [8:0]  blend_s;
  logic [8:0]  edge_t;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [31:0] upper_mem [sges_pkg::MaxWidth];
  logic [31:0] middle_mem [sges_pkg::MaxWidth];
  logic [31:0] win [9];

  sges_pkg::out_word_t pending_pixels [$];
  int err_count;
  int words_sent;
  int words_checked;
  int smoothed_seen;
  bit sender_gaps;
  bit receiver_gaps;
  int long_hold;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [7:0] blend_channel(input int sh, input longint s);
    longint c [9];
    longint gq;
    longint v;
    for (int i = 0; i < 9; i++) c[i] = (win[i] >> sh) & 32'hFF;
    gq = 317 * (c[0] + c[2] + c[6] + c[8]) + 506 * (c[1] + c[3] + c[5] + c[7]) + 803 * c[4];
    v = (c[4] * (256 - s) * 4096 + gq * s) >>> 20;
    return v[7:0];
  endfunction

  task automatic predict_pixel(input sges_pkg::in_word_t w);
    int unsigned wd;
    int unsigned ht;
    int unsigned x;
    int unsigned y;
    logic [31:0] up;
    logic [31:0] mid;
    logic [31:0] pix;
    longint l [9];
    longint gx;
    longint gy;
    longint mag;
    longint tt;
    longint s;
    sges_pkg::out_word_t o;
    sges_pkg::out_word_t res [$];
    wd = (frame_w == 0) ? 1 :
         ((frame_w > sges_pkg::MaxWidth) ? sges_pkg::MaxWidth : frame_w);
    ht = (frame_h == 0) ? 1 :
         ((frame_h > sges_pkg::MaxWidth) ? sges_pkg::MaxWidth : frame_h);
    pix = w.pixel_argb;
    if (w.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= wd) col_pos = 0;
    if (row_pos >= ht) row_pos = 0;
    x = col_pos;
    y = row_pos;
    up = upper_mem[x];
    mid = middle_mem[x];
    upper_mem[x] = mid;
    middle_mem[x] = pix;
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = pix;
    if (x >= 2 && y >= 2) begin
      for (int i = 0; i < 9; i++) begin
        l[i] = 77 * win[i][23:16] + 150 * win[i][15:8] + 29 * win[i][7:0];
      end
      gx = -l[0] + l[2] - 2 * l[3] + 2 * l[5] - l[6] + l[8];
      gy = -l[0] - 2 * l[1] - l[2] + l[6] + 2 * l[7] + l[8];
      mag = gx * gx + gy * gy;
      tt = ((edge_t > 256) ? 256 : edge_t) * 255;
      o = '0;
      o.out_x = 12'(x - 1);
      o.out_y = 12'(y - 1);
      if (mag > tt * tt) begin
        s = (blend_s > 256) ? 256 : blend_s;
        o.out_pixel = {win[4][31:24], blend_channel(16, s), blend_channel(8, s),
                       blend_channel(0, s)};
        o.was_smoothed = 1'b1;
      end else begin
        o.out_pixel = win[4];
      end
      res.push_back(o);
    end
    if (x == 0 || y == 0 || x == wd - 1 || y == ht - 1) begin
      o = '0;
      o.out_pixel = pix;
      o.out_x = 12'(x);
      o.out_y = 12'(y);
      res.push_back(o);
    end
    if (res.size() > 0) res[res.size() - 1].last_of_run = 1'b1;
    foreach (res[i]) pending_pixels.push_back(res[i]);
    if (x + 1 >= wd) begin
      col_pos = 0;
      row_pos = (y + 1 >= ht) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  task automatic send_pixel(input bit sof, input logic [31:0] p);
    sges_pkg::in_word_t w;
    bit stalled;
    int gap;
    w.start_of_frame = sof;
    w.pixel_argb = p;
    gap = sender_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    predict_pixel(w);
    words_sent++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input sges_pkg::cfg_reg_t r, input logic [12:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      sges_pkg::REG_WIDTH:    frame_w = v;
      sges_pkg::REG_HEIGHT:   frame_h = v;
      sges_pkg::REG_STRENGTH: blend_s = v[8:0];
      sges_pkg::REG_THRESH:   edge_t = v[8:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [12:0] wd, input logic [12:0] ht,
                              input logic [12:0] s, input logic [12:0] t);
    go_quiet();
    write_reg(sges_pkg::REG_WIDTH, wd);
    write_reg(sges_pkg::REG_HEIGHT, ht);
    write_reg(sges_pkg::REG_STRENGTH, s);
    write_reg(sges_pkg::REG_THRESH, t);
  endtask

  // receiver: stall handling and checking
  logic      seen_valid;
  logic      seen_stall;
  sges_pkg::out_word_t seen_word;
  int        rx_wait;

  always @(negedge clk) begin
    seen_valid <= out_valid;
    seen_stall <= out_stall;
    seen_word <= out_word;
  end

  always @(posedge clk) begin
    sges_pkg::out_word_t e;
    bit took;
    took = rst_n && seen_valid && !seen_stall;
    if (took) begin
      words_checked++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected word: pixel %h x %0d y %0d", seen_word.out_pixel,
               seen_word.out_x, seen_word.out_y);
        err_count++;
      end else begin
        e = pending_pixels.pop_front();
        if (seen_word.was_smoothed) smoothed_seen++;
        if (seen_word.out_pixel !== e.out_pixel) begin
          $error("out_pixel expected %h actual %h", e.out_pixel, seen_word.out_pixel);
          err_count++;
        end
        if (seen_word.out_x !== e.out_x) begin
          $error("out_x expected %0d actual %0d", e.out_x, seen_word.out_x);
          err_count++;
        end
        if (seen_word.out_y !== e.out_y) begin
          $error("out_y expected %0d actual %0d", e.out_y, seen_word.out_y);
          err_count++;
        end
        if (seen_word.was_smoothed !== e.was_smoothed) begin
          $error("was_smoothed expected %0b actual %0b", e.was_smoothed,
                 seen_word.was_smoothed);
          err_count++;
        end
        if (seen_word.last_of_run !== e.last_of_run) begin
          $error("last_of_run expected %0b actual %0b", e.last_of_run,
                 seen_word.last_of_run);
          err_count++;
        end
      end
    end
    if (took) rx_wait = receiver_gaps ? $urandom_range(0, 4) : 0;
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] edge_pixel(input int kind);
    logic [31:0] p;
    case (kind)
      0: p = 32'h0000_0000;
      1: p = 32'hFFFF_FFFF;
      2: p = {8'($urandom), 24'h000000};
      3: p = {8'($urandom), 24'hFFFFFF};
      default: p = $urandom;
    endcase
    return p;
  endfunction

  task automatic test_reset_defaults();
    send_pixel(1'b0, 32'h12345678);
    for (int i = 0; i < 4; i++) send_pixel(1'b0, $urandom);
  endtask

  task automatic test_extreme_pixels();
    set_geometry(13'd4, 13'd4, 13'd256, 13'd0);
    for (int i = 0; i < 16; i++) begin
      send_pixel(i == 0, ((i + i / 4) % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
    end
    set_geometry(13'd3, 13'd3, 13'd0, 13'd0);
    for (int i = 0; i < 9; i++) send_pixel(i == 0, 32'h5A5A_5A5A);
  endtask

  task automatic test_stale_coordinates();
    set_geometry(13'd6, 13'd5, 13'd100, 13'd10);
    for (int i = 0; i < 14; i++) send_pixel(i == 0, $urandom);
    go_quiet();
    write_reg(sges_pkg::REG_WIDTH, 13'd2);
    write_reg(sges_pkg::REG_HEIGHT, 13'd2);
    for (int i = 0; i < 4; i++) send_pixel(1'b0, $urandom);
  endtask

  task automatic test_register_extremes();
    set_geometry(13'd0, 13'd0, 13'd511, 13'd511);
    for (int i = 0; i < 3; i++) send_pixel(i == 1, $urandom);
    set_geometry(13'd8191, 13'd8191, 13'd256, 13'd256);
    for (int i = 0; i < 4; i++) send_pixel(i == 0, $urandom);
    set_geometry(13'd4096, 13'd1, 13'd1, 13'd1);
    for (int i = 0; i < 4; i++) send_pixel(i == 0, $urandom);
    set_geometry(13'd1, 13'd4096, 13'd255, 13'd255);
    for (int i = 0; i < 4; i++) send_pixel(i == 0, $urandom);
    set_geometry(13'd3, 13'd4, 13'd511, 13'd0);
    for (int i = 0; i < 12; i++) send_pixel(i == 0, edge_pixel($urandom_range(0, 4)));
  endtask

  task automatic test_back_pressure();
    set_geometry(13'd5, 13'd5, 13'd200, 13'd5);
    sender_gaps = 1'b0;
    long_hold = 80;
    for (int i = 0; i < 25; i++) send_pixel(i == 0, edge_pixel($urandom_range(0, 4)));
    go_quiet();
  endtask

  task automatic test_random_frames();
    int wd;
    int ht;
    int n;
    logic [31:0] base;
    while (words_sent < 620) begin
      wd = $urandom_range(3, 9);
      ht = $urandom_range(3, 7);
      set_geometry(13'(wd), 13'(ht),
                   ($urandom_range(0, 5) == 0) ? 13'd511 : 13'($urandom_range(0, 256)),
                   ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 511))
                                               : 13'($urandom_range(0, 40)));
      sender_gaps = $urandom_range(0, 3) != 0;
      receiver_gaps = $urandom_range(0, 3) != 0;
      n = ($urandom_range(0, 3) != 0) ? wd * ht : $urandom_range(1, wd * ht + wd * 2);
      base = $urandom;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: send_pixel(i == 0, base ^ ($urandom & 32'h0F0F_0F0F));
          1: send_pixel(i == 0, base);
          default: send_pixel(i == 0, edge_pixel($urandom_range(0, 4)));
        endcase
      end
      if ($urandom_range(0, 4) == 0) send_pixel(1'b1, $urandom);
    end
  endtask

  initial begin
    frame_w = 13'd640;
    frame_h = 13'd480;
    blend_s = 9'd128;
    edge_t = 9'd26;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < sges_pkg::MaxWidth; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    err_count = 0;
    words_sent = 0;
    words_checked = 0;
    smoothed_seen = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    long_hold = 0;
    rx_wait = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sges_pkg::REG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_pixels();
    test_stale_coordinates();
    test_register_extremes();
    test_back_pressure();
    test_random_frames();
    go_quiet();
    $display("sent %0d pixels, checked %0d words, %0d of them smoothed", words_sent,
             words_checked, smoothed_seen);
    $display("covered register extremes, stale coordinates, back pressure, random frames");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sges_pkg.sv
sv/sges_fifo.sv
sv/sges_front.sv
sv/sges_back.sv
sv/sobel_gated_edge_smoothing.sv
sv/sges_checker.sv
tb/sv/sobel_gated_edge_smoothing_tb.sv
